/* hw/rtl/cdtq_pkg.sv */
// Shared types and constants for the connection deadline timer queue.
// No dependencies; imported by every module of the block but cdtq_ram.
package cdtq_pkg;

  localparam int DEPTH   = 64;
  localparam int DUE_MAX = (DEPTH < 64) ? DEPTH : 64;
  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int TW      = $clog2(DUE_MAX);

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_TICK = 2'd1,
    OP_DEL  = 2'd2,
    OP_CLR  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_FULL    = 3'd1,
    ST_EXPIRED = 3'd2,
    ST_NONE    = 3'd3,
    ST_DELETED = 3'd4,
    ST_CLEARED = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    UOP_IDLE,
    UOP_CAP,
    UOP_DISP,
    UOP_ADD_RD,
    UOP_ADD_CMP,
    UOP_TA_RD,
    UOP_TA_CMP,
    UOP_TB_RD,
    UOP_TB_CMP,
    UOP_TC_RD,
    UOP_TC_WR,
    UOP_DL_RD,
    UOP_DL_CMP,
    UOP_RESP
  } uop_t;

  typedef struct packed {
    logic [31:0] dl;
    logic [15:0] conn;
    logic [31:0] seq;
  } entry_t;

  typedef struct packed {
    uop_t    uop;
    status_t st;
  } dp_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    full;
    logic    tick_go;
    logic    a_zero;
    logic    a_lt_held;
    logic    a_lt_due;
    logic    gt_nd;
    logic    le_now;
    logic    c_last;
    logic    out_free;
  } dp_sts_t;

endpackage

/* hw/rtl/cdtq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cdtq_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/cdtq_dp.sv */
// Datapath: sorted timer table, expiry buffer, counters, config and result register.
// Depends on cdtq_pkg and cdtq_ram.
module cdtq_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata,
  input  logic [1:0]        in_opcode,
  input  logic [15:0]       in_conn_id,
  input  logic [31:0]       in_conn_sequence,
  input  logic [31:0]       in_now,
  input  cdtq_pkg::dp_cmd_t cmd,
  output cdtq_pkg::dp_sts_t sts,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_status,
  output logic [15:0]       out_conn_id,
  output logic [31:0]       out_sequence,
  output logic [31:0]       out_old_deadline,
  output logic [cdtq_pkg::CW-1:0] out_entry_count,
  output logic              out_last
);
  import cdtq_pkg::*;

  logic [15:0]   wait_r;
  logic [CW-1:0] held_r, held_nxt;
  logic [31:0]   earliest_r, earliest_nxt;
  opcode_t       op_r;
  logic [15:0]   id_r;
  logic [31:0]   seq_r, now_r, nd_r;
  logic [CW-1:0] a_r, a_nxt, b_r, b_nxt, c_r, c_nxt;
  logic          ov_r, ov_nxt;
  status_t       os_r, os_nxt;
  logic [15:0]   oc_r, oc_nxt;
  logic [31:0]   oq_r, oq_nxt, od_r, od_nxt;
  logic [CW-1:0] on_r, on_nxt;
  logic          ol_r, ol_nxt;

  logic [32:0]   sum;
  logic [31:0]   nd_in;
  logic          tw_en, mw_en, out_free;
  logic [AW-1:0] tw_addr, tr_addr;
  entry_t        tw_data, trd, mrd, new_e;
  logic [CW-1:0] a_m1, a_sub_b, a_add_c;

  assign sum    = {1'b0, in_now} + {17'b0, wait_r};
  assign nd_in  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  assign a_m1   = a_r - CW'(1);
  assign a_sub_b = a_r - b_r;
  assign a_add_c = a_r + c_r;
  assign new_e  = '{dl: nd_r, conn: id_r, seq: seq_r};
  assign out_free = !ov_r || out_ready;
  assign tr_addr = (cmd.uop == UOP_ADD_RD) ? a_m1[AW-1:0] : a_r[AW-1:0];

  cdtq_ram #(.W($bits(entry_t)), .D(DEPTH)) u_tab (
    .clk(clk), .we(tw_en), .waddr(tw_addr), .wdata(tw_data),
    .raddr(tr_addr), .rdata(trd)
  );

  cdtq_ram #(.W($bits(entry_t)), .D(DUE_MAX)) u_due (
    .clk(clk), .we(mw_en), .waddr(a_r[TW-1:0]), .wdata(trd),
    .raddr(c_r[TW-1:0]), .rdata(mrd)
  );

  always_comb begin
    sts.op        = op_r;
    sts.full      = (held_r == CW'(DEPTH));
    sts.tick_go   = (held_r != '0) && (earliest_r < now_r);
    sts.a_zero    = (a_r == '0);
    sts.a_lt_held = (a_r < held_r);
    sts.a_lt_due  = (a_r < CW'(DUE_MAX));
    sts.gt_nd     = (trd.dl > nd_r);
    sts.le_now    = (trd.dl <= now_r);
    sts.c_last    = (c_r + CW'(1) == b_r);
    sts.out_free  = out_free;
  end

  always_comb begin
    held_nxt = held_r; earliest_nxt = earliest_r;
    a_nxt = a_r; b_nxt = b_r; c_nxt = c_r;
    tw_en = 1'b0; tw_addr = a_r[AW-1:0]; tw_data = trd; mw_en = 1'b0;
    ov_nxt = ov_r && !out_ready;
    os_nxt = os_r; oc_nxt = oc_r; oq_nxt = oq_r; od_nxt = od_r;
    on_nxt = on_r; ol_nxt = ol_r;
    case (cmd.uop)
      UOP_CAP: begin
        b_nxt = '0;
        c_nxt = '0;
      end
      UOP_DISP: begin
        a_nxt = (op_r == OP_ADD) ? held_r : '0;
        if (op_r == OP_CLR) begin
          held_nxt = '0;
        end
      end
      UOP_ADD_RD: begin
        if (a_r == '0) begin
          tw_en = 1'b1; tw_addr = '0; tw_data = new_e;
          earliest_nxt = nd_r;
          held_nxt = held_r + CW'(1);
        end
      end
      UOP_ADD_CMP: begin
        tw_en = 1'b1;
        if (trd.dl > nd_r) begin
          a_nxt = a_m1;
        end else begin
          tw_data = new_e;
          held_nxt = held_r + CW'(1);
        end
      end
      UOP_TA_RD: begin
        if (!(a_r < held_r && a_r < CW'(DUE_MAX))) begin
          b_nxt = a_r;
        end
      end
      UOP_TA_CMP: begin
        if (trd.dl <= now_r) begin
          mw_en = 1'b1;
          a_nxt = a_r + CW'(1);
        end else begin
          b_nxt = a_r;
        end
      end
      UOP_TB_RD: begin
        if (!(a_r < held_r)) begin
          a_nxt = a_sub_b;
          if (a_r == b_r) earliest_nxt = nd_r;
        end
      end
      UOP_TB_CMP: begin
        if (trd.dl <= nd_r) begin
          tw_en = 1'b1; tw_addr = a_sub_b[AW-1:0];
          if (a_r == b_r) earliest_nxt = trd.dl;
          a_nxt = a_r + CW'(1);
        end else begin
          a_nxt = a_sub_b;
          if (a_r == b_r) earliest_nxt = nd_r;
        end
      end
      UOP_TC_WR: begin
        if (out_free) begin
          tw_en = 1'b1; tw_addr = a_add_c[AW-1:0];
          tw_data = '{dl: nd_r, conn: mrd.conn, seq: mrd.seq};
          c_nxt = c_r + CW'(1);
          ov_nxt = 1'b1; os_nxt = ST_EXPIRED; oc_nxt = mrd.conn; oq_nxt = mrd.seq;
          od_nxt = mrd.dl; on_nxt = held_r; ol_nxt = (c_r + CW'(1) == b_r);
        end
      end
      UOP_DL_RD: begin
        if (!(a_r < held_r)) begin
          held_nxt = b_r;
        end
      end
      UOP_DL_CMP: begin
        if (trd.conn != id_r) begin
          tw_en = 1'b1; tw_addr = b_r[AW-1:0];
          if (b_r == '0) earliest_nxt = trd.dl;
          b_nxt = b_r + CW'(1);
        end
        a_nxt = a_r + CW'(1);
      end
      UOP_RESP: begin
        if (out_free) begin
          ov_nxt = 1'b1; os_nxt = cmd.st; oc_nxt = id_r;
          oq_nxt = (cmd.st == ST_ADDED || cmd.st == ST_FULL) ? seq_r : '0;
          od_nxt = '0;
          on_nxt = (cmd.st == ST_DELETED) ? a_sub_b : held_r;
          ol_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_r     <= 16'd20;
      held_r     <= '0;
      earliest_r <= '0;
      ov_r       <= 1'b0;
    end else begin
      if (cfg_we) wait_r <= cfg_wdata;
      held_r     <= held_nxt;
      earliest_r <= earliest_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.uop == UOP_CAP) begin
      op_r  <= opcode_t'(in_opcode);
      id_r  <= in_conn_id;
      seq_r <= in_conn_sequence;
      now_r <= in_now;
      nd_r  <= nd_in;
    end
    a_r <= a_nxt; b_r <= b_nxt; c_r <= c_nxt;
    os_r <= os_nxt; oc_r <= oc_nxt; oq_r <= oq_nxt;
    od_r <= od_nxt; on_r <= on_nxt; ol_r <= ol_nxt;
  end

  assign out_valid        = ov_r;
  assign out_status       = os_r;
  assign out_conn_id      = oc_r;
  assign out_sequence     = oq_r;
  assign out_old_deadline = od_r;
  assign out_entry_count  = on_r;
  assign out_last         = ol_r;

`ifndef SYNTH
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CW'(DEPTH)) else $error("held count beyond table depth");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.uop == UOP_RESP || cmd.uop == UOP_TC_WR) && out_free |=> ov_r)
    else $error("result load lost");
  a_del_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.uop == UOP_DL_RD || cmd.uop == UOP_DL_CMP) |-> b_r <= a_r)
    else $error("compaction write overtook read");
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    tw_en |-> {1'b0, tw_addr} <= {1'b0, held_r})
    else $error("table write past end");
`endif

endmodule

/* hw/rtl/cdtq_ctrl.sv */
// Controller state machine sequencing add, tick, delete and clear passes.
// Depends on cdtq_pkg.
module cdtq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cdtq_pkg::dp_sts_t sts,
  output cdtq_pkg::dp_cmd_t cmd
);
  import cdtq_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE    = 13'h0001,
    S_DISP    = 13'h0002,
    S_ADD_RD  = 13'h0004,
    S_ADD_CMP = 13'h0008,
    S_TA_RD   = 13'h0010,
    S_TA_CMP  = 13'h0020,
    S_TB_RD   = 13'h0040,
    S_TB_CMP  = 13'h0080,
    S_TC_RD   = 13'h0100,
    S_TC_WR   = 13'h0200,
    S_DL_RD   = 13'h0400,
    S_DL_CMP  = 13'h0800,
    S_RESP    = 13'h1000
  } state_t;

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    cmd.st    = st_r;
    cmd.uop   = UOP_IDLE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.uop = UOP_CAP;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        cmd.uop = UOP_DISP;
        case (sts.op)
          OP_ADD: begin
            if (sts.full) begin
              st_nxt = ST_FULL; state_nxt = S_RESP;
            end else begin
              st_nxt = ST_ADDED; state_nxt = S_ADD_RD;
            end
          end
          OP_TICK: begin
            if (sts.tick_go) begin
              state_nxt = S_TA_RD;
            end else begin
              st_nxt = ST_NONE; state_nxt = S_RESP;
            end
          end
          OP_DEL: begin
            st_nxt = ST_DELETED; state_nxt = S_DL_RD;
          end
          default: begin
            st_nxt = ST_CLEARED; state_nxt = S_RESP;
          end
        endcase
      end
      S_ADD_RD: begin
        cmd.uop = UOP_ADD_RD;
        state_nxt = sts.a_zero ? S_RESP : S_ADD_CMP;
      end
      S_ADD_CMP: begin
        cmd.uop = UOP_ADD_CMP;
        state_nxt = sts.gt_nd ? S_ADD_RD : S_RESP;
      end
      S_TA_RD: begin
        cmd.uop = UOP_TA_RD;
        state_nxt = (sts.a_lt_held && sts.a_lt_due) ? S_TA_CMP : S_TB_RD;
      end
      S_TA_CMP: begin
        cmd.uop = UOP_TA_CMP;
        state_nxt = sts.le_now ? S_TA_RD : S_TB_RD;
      end
      S_TB_RD: begin
        cmd.uop = UOP_TB_RD;
        state_nxt = sts.a_lt_held ? S_TB_CMP : S_TC_RD;
      end
      S_TB_CMP: begin
        cmd.uop = UOP_TB_CMP;
        state_nxt = sts.gt_nd ? S_TC_RD : S_TB_RD;
      end
      S_TC_RD: begin
        cmd.uop = UOP_TC_RD;
        state_nxt = S_TC_WR;
      end
      S_TC_WR: begin
        cmd.uop = UOP_TC_WR;
        if (sts.out_free) begin
          state_nxt = sts.c_last ? S_IDLE : S_TC_RD;
        end
      end
      S_DL_RD: begin
        cmd.uop = UOP_DL_RD;
        state_nxt = sts.a_lt_held ? S_DL_CMP : S_RESP;
      end
      S_DL_CMP: begin
        cmd.uop = UOP_DL_CMP;
        state_nxt = S_DL_RD;
      end
      S_RESP: begin
        cmd.uop = UOP_RESP;
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_ADDED;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

`ifndef SYNTH
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state register corrupted");
  a_resp_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RESP && sts.out_free |=> state_r == S_IDLE)
    else $error("response not retired");
  a_tick_guard: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DISP && sts.op == OP_TICK && !sts.tick_go |=> state_r == S_RESP)
    else $error("idle tick entered scan");
`endif

endmodule

/* hw/rtl/connection_deadline_timer_queue_unit.sv */
// Connection deadline timer queue: up to DEPTH timers sorted by deadline in one RAM.
// The controller stalls while out_ready holds a result beat. One beat at a time.
// Reset (rst_n low, synchronous): table empty, wait_time 20, no result pending.
// Depends on cdtq_pkg, cdtq_ctrl, cdtq_dp, cdtq_ram.
module connection_deadline_timer_queue_unit (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: wait_time
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  // command beat
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_conn_id,
  input  logic [31:0] in_conn_sequence,
  input  logic [31:0] in_now,
  // result beats
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [15:0] out_conn_id,
  output logic [31:0] out_sequence,
  output logic [31:0] out_old_deadline,
  output logic [cdtq_pkg::CW-1:0] out_entry_count,
  output logic        out_last
);
  import cdtq_pkg::*;

  // Controller walks the table with a read state and a compare or write state per entry (RAM read is
  // registered); the datapath owns the table, the due buffer and all counters.
  // The next command beat is taken the cycle after the last result is loaded.
  dp_cmd_t cmd;
  dp_sts_t sts;

  cdtq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .sts(sts), .cmd(cmd)
  );

  cdtq_dp u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_opcode(in_opcode), .in_conn_id(in_conn_id),
    .in_conn_sequence(in_conn_sequence), .in_now(in_now),
    .cmd(cmd), .sts(sts),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_conn_id(out_conn_id),
    .out_sequence(out_sequence), .out_old_deadline(out_old_deadline),
    .out_entry_count(out_entry_count), .out_last(out_last)
  );

endmodule

/* bench/connection_deadline_timer_queue_unit_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for connection_deadline_timer_queue_unit: a clocked driver and monitor,
// with a built-in scoreboard that tracks the sorted timer table. Depends on cdtq_pkg and the RTL.
module connection_deadline_timer_queue_unit_test;
  import cdtq_pkg::*;

  typedef struct {
    opcode_t     op;
    logic [15:0] conn;
    logic [31:0] seq;
    logic [31:0] now;
  } cmd_beat_t;

  typedef struct {
    status_t     st;
    logic [15:0] conn;
    logic [31:0] seq;
    logic [31:0] old_dl;
    logic [6:0]  cnt;
    logic        last;
  } timer_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [15:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_opcode;
  logic [15:0] in_conn_id;
  logic [31:0] in_conn_sequence;
  logic [31:0] in_now;
  logic out_valid;
  logic out_ready;
  logic [2:0] out_status;
  logic [15:0] out_conn_id;
  logic [31:0] out_sequence;
  logic [31:0] out_old_deadline;
  logic [CW-1:0] out_entry_count;
  logic out_last;

  connection_deadline_timer_queue_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode),
    .in_conn_id(in_conn_id), .in_conn_sequence(in_conn_sequence), .in_now(in_now),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_conn_id(out_conn_id), .out_sequence(out_sequence),
    .out_old_deadline(out_old_deadline), .out_entry_count(out_entry_count),
    .out_last(out_last)
  );

  // Stimulus and scoreboard state
  cmd_beat_t     pending_cmds[$];
  timer_result_t expected_results[$];
  int            tx_idle_pct;
  int            rx_idle_pct;
  int            errors;

  // Shadow of the timer table, kept sorted by deadline, ties in insertion order
  logic [31:0] tbl_dl[DEPTH];
  logic [15:0] tbl_conn[DEPTH];
  logic [31:0] tbl_seq[DEPTH];
  int          tbl_held;
  logic [31:0] tbl_first;
  logic [15:0] shadow_wait;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] deadline_from(logic [31:0] t);
    logic [32:0] d;
    d = {1'b0, t} + {17'd0, shadow_wait};
    return d[32] ? 32'hFFFF_FFFF : d[31:0];
  endfunction

  // New entry goes after every entry whose deadline is <= its own
  task automatic table_insert(logic [31:0] dl, logic [15:0] c, logic [31:0] s);
    int pos;
    pos = 0;
    while (pos < tbl_held && tbl_dl[pos] <= dl) pos++;
    for (int k = tbl_held; k > pos; k--) begin
      tbl_dl[k] = tbl_dl[k-1];
      tbl_conn[k] = tbl_conn[k-1];
      tbl_seq[k] = tbl_seq[k-1];
    end
    tbl_dl[pos] = dl;
    tbl_conn[pos] = c;
    tbl_seq[pos] = s;
    tbl_held++;
  endtask

  task automatic push_result(status_t st, logic [15:0] c, logic [31:0] s, logic [31:0] od,
                             int cnt, logic lst);
    timer_result_t r;
    r.st = st; r.conn = c; r.seq = s; r.old_dl = od; r.cnt = cnt[6:0]; r.last = lst;
    expected_results.insert(expected_results.size(), r);
  endtask

  // Works out the result beats of one accepted command and updates the shadow table
  task automatic predict_timer_cmd(cmd_beat_t b);
    logic [31:0] due_dl[64];
    logic [15:0] due_conn[64];
    logic [31:0] due_seq[64];
    int due;
    int w;
    int removed;
    logic [31:0] nd;
    case (b.op)
      OP_ADD: begin
        if (tbl_held >= DEPTH) begin
          push_result(ST_FULL, b.conn, b.seq, 32'd0, tbl_held, 1'b1);
        end else begin
          table_insert(deadline_from(b.now), b.conn, b.seq);
          tbl_first = tbl_dl[0];
          push_result(ST_ADDED, b.conn, b.seq, 32'd0, tbl_held, 1'b1);
        end
      end
      OP_TICK: begin
        due = 0;
        if (tbl_held != 0 && tbl_first < b.now) begin
          while (due < tbl_held && due < 64 && tbl_dl[due] <= b.now) begin
            due_dl[due] = tbl_dl[due];
            due_conn[due] = tbl_conn[due];
            due_seq[due] = tbl_seq[due];
            due++;
          end
        end
        if (due == 0) begin
          push_result(ST_NONE, b.conn, 32'd0, 32'd0, tbl_held, 1'b1);
        end else begin
          for (int k = due; k < tbl_held; k++) begin
            tbl_dl[k-due] = tbl_dl[k];
            tbl_conn[k-due] = tbl_conn[k];
            tbl_seq[k-due] = tbl_seq[k];
          end
          tbl_held -= due;
          // every due entry re-armed once, after equal deadlines
          nd = deadline_from(b.now);
          for (int k = 0; k < due; k++) table_insert(nd, due_conn[k], due_seq[k]);
          tbl_first = tbl_dl[0];
          for (int k = 0; k < due; k++)
            push_result(ST_EXPIRED, due_conn[k], due_seq[k], due_dl[k], tbl_held, k + 1 == due);
        end
      end
      OP_DEL: begin
        w = 0;
        for (int r = 0; r < tbl_held; r++) begin
          if (tbl_conn[r] != b.conn) begin
            tbl_dl[w] = tbl_dl[r];
            tbl_conn[w] = tbl_conn[r];
            tbl_seq[w] = tbl_seq[r];
            w++;
          end
        end
        removed = tbl_held - w;
        tbl_held = w;
        if (tbl_held > 0) tbl_first = tbl_dl[0];
        push_result(ST_DELETED, b.conn, 32'd0, 32'd0, removed, 1'b1);
      end
      default: begin
        tbl_held = 0;
        push_result(ST_CLEARED, b.conn, 32'd0, 32'd0, 0, 1'b1);
      end
    endcase
  endtask

  // Driver: predict on acceptance, then maybe present the next beat
  always @(posedge clk) begin
    cmd_beat_t nxt;
    cmd_beat_t acc;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_opcode <= 2'd0;
      in_conn_id <= 16'd0;
      in_conn_sequence <= 32'd0;
      in_now <= 32'd0;
    end else begin
      if (in_valid && in_ready) begin
        acc.op = opcode_t'(in_opcode);
        acc.conn = in_conn_id;
        acc.seq = in_conn_sequence;
        acc.now = in_now;
        predict_timer_cmd(acc);
      end
      if (!in_valid || in_ready) begin
        if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          nxt = pending_cmds[0];
          pending_cmds.delete(0);
          in_opcode <= nxt.op;
          in_conn_id <= nxt.conn;
          in_conn_sequence <= nxt.seq;
          in_now <= nxt.now;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result beat against the oldest expectation
  always @(posedge clk) begin
    timer_result_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat status %0d conn %h", $time, out_status,
                   out_conn_id);
          errors++;
        end else begin
          e = expected_results[0];
          expected_results.delete(0);
          if (out_status !== e.st) begin
            $display("%0t: status exp %0d got %0d", $time, e.st, out_status); errors++;
          end
          if (out_conn_id !== e.conn) begin
            $display("%0t: conn_id exp %h got %h", $time, e.conn, out_conn_id); errors++;
          end
          if (out_sequence !== e.seq) begin
            $display("%0t: sequence exp %h got %h", $time, e.seq, out_sequence); errors++;
          end
          if (out_old_deadline !== e.old_dl) begin
            $display("%0t: old_deadline exp %h got %h", $time, e.old_dl, out_old_deadline);
            errors++;
          end
          if (out_entry_count !== e.cnt) begin
            $display("%0t: entry_count exp %0d got %0d", $time, e.cnt, out_entry_count);
            errors++;
          end
          if (out_last !== e.last) begin
            $display("%0t: last exp %b got %b", $time, e.last, out_last); errors++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  task automatic queue_cmd(opcode_t op, logic [15:0] c, logic [31:0] s, logic [31:0] t);
    cmd_beat_t b;
    b.op = op; b.conn = c; b.seq = s; b.now = t;
    pending_cmds.insert(pending_cmds.size(), b);
  endtask

  // Block until every beat is sent and every result has come back
  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_wait_time(logic [15:0] v);
    wait_drained();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    shadow_wait = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly small connection pool so deletes hit; sometimes full-range ids
  function automatic logic [15:0] pick_conn();
    return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
  endfunction

  task automatic queue_random_traffic(int n);
    logic [31:0] clock_now;
    int r;
    int made;
    clock_now = $urandom_range(0, 1000);
    made = 0;
    while (made < n) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        // burst of adds at one time: fills the table, overflows it, many equal deadlines
        repeat (66) queue_cmd(OP_ADD, pick_conn(), $urandom, clock_now);
        made += 66;
      end else if (r < 48) begin
        queue_cmd(OP_ADD, pick_conn(), $urandom, clock_now);
        made++;
      end else if (r < 75) begin
        clock_now += $urandom_range(0, shadow_wait < 40 ? 40 : 2 * shadow_wait);
        queue_cmd(OP_TICK, pick_conn(), $urandom, clock_now);
        made++;
      end else if (r < 87) begin
        queue_cmd(OP_DEL, pick_conn(), $urandom, $urandom);
        made++;
      end else if (r < 90) begin
        queue_cmd(OP_CLR, pick_conn(), $urandom, $urandom);
        made++;
      end else if (r < 94) begin
        // jump the clock: near the top of the time range or anywhere
        clock_now = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 70000)
                                                : $urandom;
      end else begin
        queue_cmd(opcode_t'($urandom_range(0, 3)), 16'($urandom), $urandom, $urandom);
        made++;
      end
    end
  endtask

  initial begin
    errors = 0;
    tbl_held = 0;
    tbl_first = 32'd0;
    shadow_wait = 16'd20;
    tx_idle_pct = 7;
    rx_idle_pct = 87;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 16'd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats at the reset wait time
    queue_cmd(OP_TICK, 16'h0000, 32'h0, 32'h0);                // empty table
    queue_cmd(OP_ADD, 16'h0000, 32'h0000_0000, 32'h0);
    queue_cmd(OP_ADD, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFF0); // saturated deadline
    queue_cmd(OP_ADD, 16'h0001, 32'h1234_5678, 32'h0);         // equal deadline, after first
    queue_cmd(OP_TICK, 16'hFFFF, 32'hFFFF_FFFF, 32'd20);       // head equals now: none
    queue_cmd(OP_TICK, 16'h0002, 32'h0, 32'd21);               // two expire
    queue_cmd(OP_DEL, 16'h7777, 32'h0, 32'h0);                 // absent connection
    queue_cmd(OP_DEL, 16'h0001, 32'h0, 32'h0);
    queue_cmd(OP_TICK, 16'h0003, 32'h0, 32'hFFFF_FFFF);        // everything due
    queue_cmd(OP_TICK, 16'h0003, 32'h0, 32'hFFFF_FFFF);        // saturated, equal now
    queue_cmd(OP_CLR, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_cmd(OP_TICK, 16'h0004, 32'h0, 32'hFFFF_FFFF);        // empty after clear
    queue_cmd(OP_DEL, 16'h0000, 32'h0, 32'h0);                 // delete on empty
    queue_cmd(OP_ADD, 16'h00AA, 32'h5555_AAAA, 32'hFFFF_FFFF);
    queue_cmd(OP_CLR, 16'h0000, 32'h0, 32'h0);

    set_wait_time(16'd1);
    queue_random_traffic(140);

    // Sender now holds off completely until all results return, then rates swap
    set_wait_time(16'hFFFF);
    tx_idle_pct = 87;
    rx_idle_pct = 7;
    queue_random_traffic(150);

    set_wait_time(16'($urandom_range(1, 65535)));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_random_traffic(150);

    wait_drained();
    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("** connection_deadline_timer_queue_unit: PASSED **");
    end else begin
      $display("** connection_deadline_timer_queue_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog for a hung handshake
  initial begin
    #(48_000_000);
    $display("** connection_deadline_timer_queue_unit: FAILED **");
    $finish;
  end

endmodule
